// ===== rtl/dlr_pkg.sv =====
// dlr_pkg: shared widths, codes and the command type of the dda line rasterizer
// used by dlr_front, dlr_queue, dlr_back and dda_line_rasterizer_top
// no dependencies
package dlr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int COLOR_BITS  = 24;

    // coordinate difference, one bit wider than a coordinate
    localparam int DIFF_W      = COORD_BITS + 1;
    // slope magnitude never exceeds 1.0, so the quotient has FRAC_BITS + 1 bits
    localparam int QUO_W       = FRAC_BITS + 1;
    localparam int SLOPE_W     = FRAC_BITS + 2;
    localparam int ACC_W       = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W      = $clog2(FRAC_BITS + 1);

    localparam int IN_DATA_W   = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input item kinds carried in tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        CMD_LINE,
        CMD_STEP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                     kind;
        logic                          major_is_x;
        logic signed [COORD_BITS-1:0]  major_pos;
        logic signed [COORD_BITS-1:0]  minor0;
        logic signed [SLOPE_W-1:0]     slope;
        logic [COORD_BITS-1:0]         count;
        logic [COLOR_BITS-1:0]         color;
    } cmd_t;

endpackage

// ===== rtl/dlr_front.sv =====
// dlr_front: accepts input items, sets up each line and divides for its slope
// one restoring step per cycle; depends on dlr_pkg
module dlr_front
    import dlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    front_state_t state_reg, state_next;

    logic                          major_x_reg;
    logic signed [COORD_BITS-1:0]  pos_reg;
    logic signed [COORD_BITS-1:0]  minor0_reg;
    logic [COORD_BITS-1:0]         den_reg;
    logic [COORD_BITS-1:0]         count_reg;
    logic                          neg_reg;
    logic [COORD_BITS:0]           rem_reg;
    logic [QUO_W-1:0]              quo_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [COLOR_BITS-1:0]         color_reg;

    logic signed [COORD_BITS-1:0]  x0, y0, x1, y1;
    logic signed [DIFF_W-1:0]      dx, dy;
    logic [DIFF_W-1:0]             adx, ady;
    logic                          major_x;
    logic signed [COORD_BITS-1:0]  i0, i1, d0, d1;
    logic                          swap;
    logic signed [COORD_BITS-1:0]  lo_i, hi_i, lo_d, hi_d;
    logic signed [DIFF_W-1:0]      den_full, num;
    logic [DIFF_W-1:0]             num_mag;
    logic                          accept;
    logic                          start_acc;

    logic [COORD_BITS:0]           shifted;
    logic [COORD_BITS+1:0]         trial;
    logic                          quo_bit;
    logic signed [SLOPE_W-1:0]     slope_pos;

    assign x0 = s_axis_tdata[COORD_BITS-1:0];
    assign y0 = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x1 = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y1 = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // endpoint ordering along the major axis
    always_comb
    begin
        dx      = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
        dy      = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
        adx     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ady     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        major_x = adx > ady;
        i0      = major_x ? x0 : y0;
        i1      = major_x ? x1 : y1;
        d0      = major_x ? y0 : x0;
        d1      = major_x ? y1 : x1;
        swap    = i1 < i0;
        lo_i    = swap ? i1 : i0;
        hi_i    = swap ? i0 : i1;
        lo_d    = swap ? d1 : d0;
        hi_d    = swap ? d0 : d1;
        den_full = $signed({hi_i[COORD_BITS-1], hi_i}) - $signed({lo_i[COORD_BITS-1], lo_i});
        num      = $signed({hi_d[COORD_BITS-1], hi_d}) - $signed({lo_d[COORD_BITS-1], lo_d});
        num_mag  = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    end

    // one restoring division step, no shift on the first (integer) quotient bit
    always_comb
    begin
        shifted = (step_reg == STEP_W'(FRAC_BITS)) ? rem_reg : {rem_reg[COORD_BITS-1:0], 1'b0};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
        quo_bit = !trial[COORD_BITS+1];
    end

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign start_acc = accept && (s_axis_tuser == ACT_START);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start_acc)
                begin
                    state_next = (den_full == '0) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign slope_pos = $signed({1'b0, quo_reg});

    always_comb
    begin
        s_axis_tready    = 1'b0;
        q_push           = 1'b0;
        q_cmd.kind       = CMD_LINE;
        q_cmd.major_is_x = major_x_reg;
        q_cmd.major_pos  = pos_reg;
        q_cmd.minor0     = minor0_reg;
        q_cmd.slope      = neg_reg ? -slope_pos : slope_pos;
        q_cmd.count      = count_reg;
        q_cmd.color      = color_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                s_axis_tready = !q_full;
                if (accept && (s_axis_tuser == ACT_STEP))
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_STEP;
                end
            end
            F_DIV:
            begin
                q_push = 1'b0;
            end
            F_PUSH:
            begin
                q_push = !q_full;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_acc)
        begin
            major_x_reg <= major_x;
            pos_reg     <= lo_i;
            minor0_reg  <= lo_d;
            den_reg     <= den_full[COORD_BITS-1:0];
            count_reg   <= (den_full == '0) ? COORD_BITS'(1) : den_full[COORD_BITS-1:0];
            neg_reg     <= num[DIFF_W-1];
            rem_reg     <= {1'b0, num_mag[COORD_BITS-1:0]};
            quo_reg     <= '0;
            step_reg    <= STEP_W'(FRAC_BITS);
            color_reg   <= s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
        end
        else if (state_reg == F_DIV)
        begin
            if (quo_bit)
            begin
                rem_reg <= trial[COORD_BITS:0];
            end
            else
            begin
                rem_reg <= shifted;
            end
            quo_reg  <= {quo_reg[QUO_W-2:0], quo_bit};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

endmodule

// ===== rtl/dlr_queue.sv =====
// dlr_queue: short command queue between the setup front and the pixel back end
// depends on dlr_pkg
module dlr_queue
    import dlr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  push_cmd,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output cmd_t  head
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign valid = cnt_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/dlr_back.sv =====
// dlr_back: holds the active line and emits one pixel per step command
// output register on the master side; depends on dlr_pkg
module dlr_back
    import dlr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  cmd_t                   q_head,
    output logic                   q_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic                          active_reg;
    logic                          major_x_reg;
    logic signed [COORD_BITS-1:0]  pos_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [SLOPE_W-1:0]     slope_reg;
    logic [COORD_BITS-1:0]         cnt_reg;
    logic [COLOR_BITS-1:0]         color_reg;

    logic                          out_valid_reg;
    logic [OUT_DATA_W-1:0]         out_data_reg;
    logic                          out_last_reg;

    logic                          out_free;
    logic                          emit;
    logic                          load;
    logic                          round_up;
    logic [COORD_BITS-1:0]         minor;
    logic [COORD_BITS-1:0]         px, py;
    logic                          last;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign load     = q_valid && (q_head.kind == CMD_LINE);
    assign emit     = q_valid && (q_head.kind == CMD_STEP) && active_reg && out_free;
    // steps while idle are dropped
    assign q_pop    = load || emit || (q_valid && (q_head.kind == CMD_STEP) && !active_reg);

    // accumulator truncated toward zero
    always_comb
    begin
        round_up = acc_reg[ACC_W-1] && (acc_reg[FRAC_BITS-1:0] != '0);
        minor    = acc_reg[FRAC_BITS+COORD_BITS-1:FRAC_BITS]
                   + {{(COORD_BITS-1){1'b0}}, round_up};
        px       = major_x_reg ? pos_reg : minor;
        py       = major_x_reg ? minor : pos_reg;
        last     = cnt_reg <= COORD_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                active_reg <= 1'b1;
            end
            else if (emit && last)
            begin
                active_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            major_x_reg <= q_head.major_is_x;
            pos_reg     <= q_head.major_pos;
            acc_reg     <= {q_head.minor0[COORD_BITS-1], q_head.minor0, {FRAC_BITS{1'b0}}};
            slope_reg   <= q_head.slope;
            cnt_reg     <= q_head.count;
            color_reg   <= q_head.color;
        end
        else if (emit)
        begin
            pos_reg <= pos_reg + COORD_BITS'(1);
            acc_reg <= acc_reg + {{(ACC_W-SLOPE_W){slope_reg[SLOPE_W-1]}}, slope_reg};
            cnt_reg <= cnt_reg - COORD_BITS'(1);
        end
        if (emit)
        begin
            out_data_reg <= OUT_DATA_W'({color_reg, py, px});
            out_last_reg <= last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/dda_line_rasterizer_top.sv =====
// dda_line_rasterizer_top: dda line rasterizer, front setup, command queue, pixel back end
// depends on dlr_pkg, dlr_front, dlr_queue, dlr_back
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata endpoints and color, tuser action
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata pixel and color, tlast last pixel
//
// the front pushes a step item straight to the queue; the back end emits one pixel per cycle
// while steps are queued and m_axis_tready is high; a start item holds the front through 17
// restoring divide steps and the hand-off to the queue, no divide when both endpoints coincide
// the back end keeps draining queued steps while the front divides
// rst_n clears the line state, the queue and the output valid
module dda_line_rasterizer_top
    import dlr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // action
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t q_cmd;
    cmd_t q_head;

    dlr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    dlr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    dlr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
